// File: rtl/sle_pkg.sv
// Shared types, codes and constants of the sorted list engine.
package sle_pkg;

  localparam int DepthDef = 16;
  localparam int DataW    = 32;
  localparam int FuncW    = 2;
  localparam int StatW    = 2;
  localparam int RemW     = 5;
  localparam int RemMax   = 31;

  typedef enum logic [FuncW-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } sle_func_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } sle_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_EMIT,
    S_READ
  } sle_state_e;

  typedef struct packed {
    logic        latch;
    logic        insert;
    logic        rem_step;
    logic        clear;
    logic        set_st;
    sle_status_e st;
    logic        emit;
    logic        rd_step;
  } sle_cmd_t;

  typedef struct packed {
    sle_func_e func;
    logic      empty;
    logic      full;
    logic      match;
    logic      cnt_zero;
    logic      rd_last;
    logic      out_free;
  } sle_stat_t;

endpackage

// File: rtl/sle_req_if.sv
// Request and response channel interfaces of the sorted list engine.
interface sle_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic signed [31:0] value;
  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface sle_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] entry;
  logic [4:0]         removed;
  logic               last;
  modport source (output valid, status, entry, removed, last, input ready);
  modport sink   (input valid, status, entry, removed, last, output ready);
endinterface

// File: rtl/sle_ctrl.sv
// Command sequencer of the sorted list engine.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  sle_stat_t  stat_i,
  output sle_cmd_t   cmd_o,
  output sle_state_e state_o
);

  sle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.st    = ST_OK;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.func)
          FN_INSERT: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = stat_i.full ? ST_FULL : ST_OK;
            cmd_o.insert = !stat_i.full;
            state_d      = S_EMIT;
          end
          FN_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_EMPTY;
              state_d      = S_EMIT;
            end else begin
              state_d = S_REMOVE;
            end
          end
          FN_READ: begin
            if (stat_i.empty) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_EMPTY;
              state_d      = S_EMIT;
            end else begin
              state_d = S_READ;
            end
          end
          default: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = stat_i.empty ? ST_EMPTY : ST_OK;
            cmd_o.clear  = 1'b1;
            state_d      = S_EMIT;
          end
        endcase
      end
      S_REMOVE: begin
        if (stat_i.match) begin
          cmd_o.rem_step = 1'b1;
        end else begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = stat_i.cnt_zero ? ST_NOTFOUND : ST_OK;
          state_d      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        if (stat_i.out_free) begin
          cmd_o.rd_step = 1'b1;
          if (stat_i.rd_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule

// File: rtl/sle_datapath.sv
// Cell chain, occupancy, counters and response register of the sorted list engine.
module sle_datapath
  import sle_pkg::*;
#(
  parameter int DEPTH = DepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [FuncW-1:0]        req_func_i,
  input  logic signed [DataW-1:0] req_value_i,
  input  sle_cmd_t                cmd_i,
  output sle_stat_t               stat_o,
  output logic                    rsp_valid_o,
  input  logic                    rsp_ready_i,
  output logic [StatW-1:0]        rsp_status_o,
  output logic signed [DataW-1:0] rsp_entry_o,
  output logic [RemW-1:0]         rsp_removed_o,
  output logic                    rsp_last_o
);

  localparam int OccW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);

  logic signed [DataW-1:0] cell_q [DEPTH];
  logic signed [DataW-1:0] cell_d [DEPTH];
  logic [DEPTH-1:0]        live, gt, ge, eq;

  logic [OccW-1:0]         occ_q, occ_d, cnt_q;
  logic [IdxW-1:0]         rd_idx_q;
  sle_func_e               func_q;
  logic signed [DataW-1:0] value_q;
  sle_status_e             st_q;

  logic                    out_valid_q;
  logic [StatW-1:0]        out_status_q;
  logic signed [DataW-1:0] out_entry_q;
  logic [RemW-1:0]         out_removed_q;
  logic                    out_last_q;
  logic [RemW-1:0]         rem_sat;
  logic                    rd_last;

  // per-cell compares against the latched request value
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      live[k] = OccW'(k) < occ_q;
      gt[k]   = live[k] && (value_q > cell_q[k]);
      ge[k]   = live[k] && (cell_q[k] >= value_q);
      eq[k]   = live[k] && (cell_q[k] == value_q);
    end
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      cell_d[k] = cell_q[k];
      if (cmd_i.insert) begin
        if (!gt[k]) begin
          if (k == 0) cell_d[k] = value_q;
          else if (gt[k-1]) cell_d[k] = value_q;
          else cell_d[k] = cell_q[k-1];
        end
      end else if (cmd_i.rem_step) begin
        if (ge[k] && k < DEPTH - 1) cell_d[k] = cell_q[k+1];
      end else if (cmd_i.rd_step) begin
        // rotate the live cells left by one
        if (OccW'(k) == occ_q - OccW'(1)) cell_d[k] = cell_q[0];
        else if (live[k] && k < DEPTH - 1) cell_d[k] = cell_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DEPTH; k++) cell_q[k] <= cell_d[k];
  end

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.insert) occ_d = occ_q + OccW'(1);
    else if (cmd_i.rem_step) occ_d = occ_q - OccW'(1);
    else if (cmd_i.clear) occ_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      cnt_q    <= '0;
      rd_idx_q <= '0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.latch) begin
        cnt_q    <= '0;
        rd_idx_q <= '0;
      end else begin
        if (cmd_i.rem_step) cnt_q <= cnt_q + OccW'(1);
        if (cmd_i.rd_step) rd_idx_q <= rd_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= sle_func_e'(req_func_i);
      value_q <= req_value_i;
    end
    if (cmd_i.set_st) st_q <= cmd_i.st;
  end

  assign rd_last = (OccW'(rd_idx_q) == occ_q - OccW'(1));
  assign rem_sat = (cnt_q > OccW'(RemMax)) ? RemW'(RemMax) : RemW'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.rd_step) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q  <= st_q;
      out_entry_q   <= '0;
      out_removed_q <= (func_q == FN_REMOVE) ? rem_sat : '0;
      out_last_q    <= 1'b1;
    end else if (cmd_i.rd_step) begin
      out_status_q  <= ST_OK;
      out_entry_q   <= cell_q[0];
      out_removed_q <= '0;
      out_last_q    <= rd_last;
    end
  end

  assign stat_o.func     = func_q;
  assign stat_o.empty    = (occ_q == '0);
  assign stat_o.full     = (occ_q >= OccW'(DEPTH));
  assign stat_o.match    = |eq;
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.rd_last  = rd_last;
  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o   = out_valid_q;
  assign rsp_status_o  = out_status_q;
  assign rsp_entry_o   = out_entry_q;
  assign rsp_removed_o = out_removed_q;
  assign rsp_last_o    = out_last_q;

endmodule

// File: rtl/sorted_list_engine.sv
// Top level of the sorted list engine: sequencer, cell chain datapath and assertions.
//
//  channel  dir  fields                          meaning
//  req_i    in   func, value                     one command per request
//  rsp_o    out  status, entry, removed, last    one result, or one per entry on read-out
//
// Insert and clear pass idle, exec and emit from acceptance to the result register.
// Remove adds a remove state with one cell-chain shift per equal entry before emit.
// Read-out rotates the chain, one result per cycle while the response register is free.
// Reset clears occupancy and control; no clearing pass. A stalled response holds the
// sequencer in its emit or read state; the next request is taken once back in idle.
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int DEPTH = DepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sle_req_if.sink   req_i,
  sle_rsp_if.source rsp_o
);

  sle_cmd_t   cmd;
  sle_stat_t  stat;
  sle_state_e state;

  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  sle_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_func_i    (req_i.func),
    .req_value_i   (req_i.value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_status_o  (rsp_o.status),
    .rsp_entry_o   (rsp_o.entry),
    .rsp_removed_o (rsp_o.removed),
    .rsp_last_o    (rsp_o.last)
  );

  a_no_back_to_back_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while previous one in flight");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == S_READ) |-> !stat.empty)
    else $error("read-out running on an empty list");

  a_insert_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.insert |-> !stat.full)
    else $error("insert into a full list");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit || cmd.rd_step) |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response register overwritten");

endmodule
